/* rtl/analog_keypad_code_lock_macros.svh */
// Assertion macros shared by the keypad code lock RTL.
`ifndef ANALOG_KEYPAD_CODE_LOCK_MACROS_SVH
`define ANALOG_KEYPAD_CODE_LOCK_MACROS_SVH

// Check on every clock edge outside reset.
`define AKCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define AKCL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/akcl_pkg.sv */
// Types, constants and lookup tables of the keypad code lock.
package akcl_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int KEY_W     = 4;
  localparam int POS_W     = 2;
  localparam int SEG_W     = 8;
  localparam int CODE_W    = 16;
  localparam int TOL_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_KEYS  = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SECRET_CODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE = 2'd1;

  localparam logic [CODE_W-1:0] SECRET_CODE_RST     = 16'd22539;
  localparam logic [TOL_W-1:0]  MATCH_TOLERANCE_RST = 6'd5;
  localparam logic [KEY_W-1:0]  EMPTY_ENTRY         = 4'd15;

  localparam logic [SAMPLE_W-1:0] REF_LEVELS [MAX_KEYS] = '{
    10'd930, 10'd912, 10'd894, 10'd877, 10'd852, 10'd837, 10'd822, 10'd808,
    10'd787, 10'd774, 10'd761, 10'd749, 10'd731, 10'd719, 10'd708, 10'd698
  };

  localparam logic [SEG_W-1:0] GLYPHS [MAX_KEYS] = '{
    8'h0C, 8'hB6, 8'h9E, 8'hEE, 8'hCC, 8'hDA, 8'hFA, 8'hF8,
    8'h0E, 8'hFE, 8'hDE, 8'h72, 8'h01, 8'h7E, 8'hEC, 8'hBC
  };

  // Release word from the sampler to the entry stage.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } key_event_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic [POS_W-1:0] position;
    logic [SEG_W-1:0] segments;
    logic             verdict_valid;
    logic             code_ok;
  } result_t;

endpackage

/* rtl/akcl_queue.sv */
// Short first-in first-out queue that decouples two pipeline sides.
`include "analog_keypad_code_lock_macros.svh"

module akcl_queue #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `AKCL_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty, "queue not empty after reset")
  `AKCL_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "queue count above depth")
  `AKCL_ASSERT(a_blocked_push, (push && full && !pop) |=> $stable(count_r), "push into full queue")

endmodule

/* rtl/akcl_front.sv */
// Sampler: matches converter samples to key levels and detects key release.
`include "analog_keypad_code_lock_macros.svh"

module akcl_front #(
  parameter int NUM_KEYS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [akcl_pkg::SAMPLE_W-1:0] sample,
  input  logic [akcl_pkg::TOL_W-1:0]    tolerance,
  output akcl_pkg::key_event_t          event_o
);

  logic                       awaiting_r, awaiting_nxt;
  logic [akcl_pkg::KEY_W-1:0] pending_r, pending_nxt;
  logic [NUM_KEYS-1:0]        near;
  logic                       hit;
  logic [akcl_pkg::KEY_W-1:0] hit_key;

  // Tolerance compares against every level in parallel.
  always_comb begin
    logic [akcl_pkg::SAMPLE_W-1:0] lvl;
    logic [akcl_pkg::SAMPLE_W-1:0] diff;
    for (int i = 0; i < NUM_KEYS; i++) begin
      lvl     = akcl_pkg::REF_LEVELS[i];
      diff    = (sample > lvl) ? (sample - lvl) : (lvl - sample);
      near[i] = (diff < {{(akcl_pkg::SAMPLE_W - akcl_pkg::TOL_W){1'b0}}, tolerance});
    end
  end

  // Lowest matching index wins.
  always_comb begin
    hit     = 1'b0;
    hit_key = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (near[i]) begin
        hit     = 1'b1;
        hit_key = akcl_pkg::KEY_W'(i);
      end
    end
  end

  always_comb begin
    awaiting_nxt  = awaiting_r;
    pending_nxt   = pending_r;
    event_o.valid = 1'b0;
    event_o.key   = pending_r;
    if (accept) begin
      if (!awaiting_r) begin
        if (hit) begin
          awaiting_nxt = 1'b1;
          pending_nxt  = hit_key;
        end
      end else if (sample == '0) begin
        awaiting_nxt  = 1'b0;
        event_o.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      pending_r  <= '0;
    end else begin
      awaiting_r <= awaiting_nxt;
      pending_r  <= pending_nxt;
    end
  end

  `AKCL_ASSERT(a_release_idles, event_o.valid |=> !awaiting_r, "release left sampler busy")

endmodule

/* rtl/akcl_back.sv */
// Entry stage: stores released keys, builds result words and the verdict.
`include "analog_keypad_code_lock_macros.svh"

module akcl_back #(
  parameter int CODE_LENGTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [akcl_pkg::KEY_W-1:0]  key,
  input  logic [akcl_pkg::CODE_W-1:0] secret_code,
  output akcl_pkg::result_t           result
);

  localparam int CNT_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  logic [CNT_W-1:0]           count_r;
  logic [akcl_pkg::KEY_W-1:0] entered_r [CODE_LENGTH];
  logic                       last;
  logic                       match;
  logic [31:0]                secret_ext;

  assign last       = (count_r == CNT_W'(CODE_LENGTH - 1));
  assign secret_ext = {16'b0, secret_code};

  // Position p checks nibble CODE_LENGTH-1-p; nibbles above the code read zero.
  always_comb begin
    logic [akcl_pkg::KEY_W-1:0] cur;
    logic [akcl_pkg::KEY_W-1:0] want;
    match = 1'b1;
    for (int p = 0; p < CODE_LENGTH; p++) begin
      cur  = (p == CODE_LENGTH - 1) ? key : entered_r[p];
      want = secret_ext[4 * (CODE_LENGTH - 1 - p) +: 4];
      if (cur != want) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    result.key_index     = key;
    result.position      = akcl_pkg::POS_W'(count_r);
    result.segments      = akcl_pkg::GLYPHS[key];
    result.verdict_valid = last;
    result.code_ok       = last && match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int p = 0; p < CODE_LENGTH; p++) begin
        entered_r[p] <= akcl_pkg::EMPTY_ENTRY;
      end
    end else if (take) begin
      if (last) begin
        count_r <= '0;
        for (int p = 0; p < CODE_LENGTH; p++) begin
          entered_r[p] <= akcl_pkg::EMPTY_ENTRY;
        end
      end else begin
        count_r <= count_r + 1'b1;
        for (int p = 0; p < CODE_LENGTH; p++) begin
          if (count_r == CNT_W'(p)) begin
            entered_r[p] <= key;
          end
        end
      end
    end
  end

  `AKCL_ASSERT(a_verdict_clears, (take && last) |=> (count_r == '0), "entry count not cleared")

endmodule

/* rtl/analog_keypad_code_lock.sv */
// Top level of the keypad code lock: config registers, sampler, queues, entry stage.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | push / full        | in_sample
//  result  | empty / pop        | out_key_index out_position out_segments
//          |                    | out_verdict_valid out_code_ok
//  config  | cfg_valid/cfg_ready| cfg_index cfg_data
//
// One sample is taken every cycle while full is low; the sixteen level compares of the sampler
// run in parallel, so the sampler sets a rate of one word per cycle.
// A release word is registered in the release queue, then in the result queue; it waits while the result queue is full.
// Reset is synchronous; no clearing pass, the block takes samples right after.
// full rises only when the two-word release queue is full, which happens when
// the two-word result queue is full and pop stays low.

module analog_keypad_code_lock #(
  parameter int NUM_KEYS    = 16,
  parameter int CODE_LENGTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [akcl_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                           empty,
  input  logic                           pop,
  output logic [akcl_pkg::KEY_W-1:0]     out_key_index,
  output logic [akcl_pkg::POS_W-1:0]     out_position,
  output logic [akcl_pkg::SEG_W-1:0]     out_segments,
  output logic                           out_verdict_valid,
  output logic                           out_code_ok,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [akcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [akcl_pkg::CODE_W-1:0]    cfg_data
);

  localparam int RES_W = $bits(akcl_pkg::result_t);

  logic [akcl_pkg::CODE_W-1:0] secret_r;
  logic [akcl_pkg::TOL_W-1:0]  tol_r;
  logic                        in_accept;
  akcl_pkg::key_event_t        rel_event;
  logic [akcl_pkg::KEY_W-1:0]  mid_key;
  logic                        mid_full, mid_empty;
  logic                        res_full;
  logic                        take;
  akcl_pkg::result_t           res_new;
  logic [RES_W-1:0]            res_head;
  akcl_pkg::result_t           res_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secret_r <= akcl_pkg::SECRET_CODE_RST;
      tol_r    <= akcl_pkg::MATCH_TOLERANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        akcl_pkg::REG_SECRET_CODE:     secret_r <= cfg_data;
        akcl_pkg::REG_MATCH_TOLERANCE: tol_r    <= cfg_data[akcl_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign full      = mid_full;
  assign in_accept = push && !full;

  akcl_front #(
    .NUM_KEYS(NUM_KEYS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .sample    (in_sample),
    .tolerance (tol_r),
    .event_o   (rel_event)
  );

  akcl_queue #(
    .WIDTH(akcl_pkg::KEY_W),
    .DEPTH(akcl_pkg::QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rel_event.valid),
    .din   (rel_event.key),
    .pop   (take),
    .dout  (mid_key),
    .full  (mid_full),
    .empty (mid_empty)
  );

  // Advance the entry stage only when the result queue has room.
  assign take = !mid_empty && !res_full;

  akcl_back #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .key         (mid_key),
    .secret_code (secret_r),
    .result      (res_new)
  );

  akcl_queue #(
    .WIDTH(RES_W),
    .DEPTH(akcl_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take),
    .din   (res_new),
    .pop   (pop),
    .dout  (res_head),
    .full  (res_full),
    .empty (empty)
  );

  assign res_word          = akcl_pkg::result_t'(res_head);
  assign out_key_index     = res_word.key_index;
  assign out_position      = res_word.position;
  assign out_segments      = res_word.segments;
  assign out_verdict_valid = res_word.verdict_valid;
  assign out_code_ok       = res_word.code_ok;

endmodule
